[sv/pst_pkg.sv]
// Shared types, constants and the arctangent table for the pie sector hit test.
`default_nettype none
package pst_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int IDX_W        = 5;

	localparam int VEC_W  = 36;
	localparam int DIFF_W = 20;
	localparam int BND_W  = 18;

	localparam logic [2:0] CFG_ANCHOR_X    = 3'd0;
	localparam logic [2:0] CFG_ANCHOR_Y    = 3'd1;
	localparam logic [2:0] CFG_ROTATION    = 3'd2;
	localparam logic [2:0] CFG_RADIUS      = 3'd3;
	localparam logic [2:0] CFG_SLICE_ANGLE = 3'd4;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	// vectoring CORDIC item as it travels down the pipe
	typedef struct packed {
		logic                     in_rad;
		logic                     zero;
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic [31:0]              z;
	} vec_t;

	// slice geometry derived from the configuration registers
	typedef struct packed {
		logic                      busy;
		logic signed [DIFF_W-1:0]  cx;
		logic signed [DIFF_W-1:0]  cy;
		logic [31:0]               rsq;
		logic signed [BND_W-1:0]   fmin;
		logic signed [BND_W-1:0]   fmax;
	} geom_t;

	function automatic logic [29:0] atan_at(input logic [IDX_W-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'h20000000;
			5'd1:  r = 30'h12E4051D;
			5'd2:  r = 30'h09FB385B;
			5'd3:  r = 30'h051111D4;
			5'd4:  r = 30'h028B0D43;
			5'd5:  r = 30'h0145D7E1;
			5'd6:  r = 30'h00A2F61E;
			5'd7:  r = 30'h00517C55;
			5'd8:  r = 30'h0028BE53;
			5'd9:  r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/pst_centre.sv]
// Configuration registers and the sequencer that derives the slice centre.
`default_nettype none
module pst_centre (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [2:0]          cfg_index,
	input  wire  [15:0]         cfg_data,
	output pst_pkg::geom_t      geom
);
	import pst_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_ROT   = 3'd3;
	localparam logic [2:0] ST_MUL_S = 3'd4;
	localparam logic [2:0] ST_MUL_C = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam logic signed [33:0] CK = 34'sh026DD3B6A;
	localparam logic [5:0] ROT_LAST = 6'(CORDIC_STEPS - 1);

	// rotation*2^23/45 = rotation*186413 + floor(rotation*23/45);
	// the small part uses ceil(2^26/45)*23 and a shift by 26, exact below 2^15
	localparam logic [31:0] RECIP_HI = 32'd186413;
	localparam logic [40:0] RECIP_LO = 41'd34300107;

	logic signed [15:0] anchor_x_q, anchor_y_q;
	logic [14:0] rotation_q, slice_angle_q;
	logic [15:0] radius_q;

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;
	logic [31:0] qhi_q;
	logic [14:0] qlo_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [50:0] prod_q;
	logic signed [DIFF_W-1:0] cx_q, cy_q;
	logic [31:0] rsq_q;

	logic        cfg_wr;
	logic [40:0] qlo_full;
	logic [31:0] z_sum;
	logic signed [33:0] z_init, xs, ys, at;
	logic signed [50:0] rounded;
	logic signed [DIFF_W-1:0] off;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	assign qlo_full = 41'(rotation_q) * RECIP_LO;
	assign z_sum    = qhi_q + 32'(qlo_q);

	assign z_init  = 34'(signed'(z_sum));
	assign xs      = x_q >>> cnt_q[IDX_W-1:0];
	assign ys      = y_q >>> cnt_q[IDX_W-1:0];
	assign at      = signed'({4'b0, atan_at(cnt_q[IDX_W-1:0])});
	assign rounded = prod_q + (51'sd1 <<< 30);
	assign off     = rounded[50:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q    <= '0;
			anchor_y_q    <= '0;
			rotation_q    <= '0;
			radius_q      <= '0;
			slice_angle_q <= 15'd5760;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_ANCHOR_X:    anchor_x_q    <= signed'(cfg_data);
				CFG_ANCHOR_Y:    anchor_y_q    <= signed'(cfg_data);
				CFG_ROTATION:    rotation_q    <= cfg_data[14:0];
				CFG_RADIUS:      radius_q      <= cfg_data;
				CFG_SLICE_ANGLE: slice_angle_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			rsq_q   <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_DIV;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_DIV: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == ROT_LAST)
						state_q <= ST_MUL_S;
				end
				ST_MUL_S: begin
					rsq_q   <= radius_q * radius_q;
					state_q <= ST_MUL_C;
				end
				ST_MUL_C: begin
					cx_q    <= DIFF_W'(anchor_x_q) + off;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					cy_q    <= DIFF_W'(anchor_y_q) - off;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: reciprocal scale by 1/45, then rotation CORDIC, then scale by radius
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIV: begin
				qhi_q <= 32'(rotation_q) * RECIP_HI;
				qlo_q <= qlo_full[40:26];
			end
			ST_INIT: begin
				y_q <= '0;
				if (z_init > 34'sh040000000) begin
					x_q <= -CK;
					z_q <= z_init - 34'sh080000000;
				end else if (z_init < -34'sh040000000) begin
					x_q <= -CK;
					z_q <= z_init + 34'sh080000000;
				end else begin
					x_q <= CK;
					z_q <= z_init;
				end
			end
			ST_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			ST_MUL_S: prod_q <= signed'({1'b0, radius_q}) * y_q;
			ST_MUL_C: prod_q <= signed'({1'b0, radius_q}) * x_q;
			default: ;
		endcase
	end

	always_comb begin
		geom.busy = state_q != ST_IDLE;
		geom.cx   = cx_q;
		geom.cy   = cy_q;
		geom.rsq  = rsq_q;
		geom.fmin = BND_W'({rotation_q, 1'b0}) - BND_W'(slice_angle_q);
		geom.fmax = BND_W'({rotation_q, 1'b0}) + BND_W'(slice_angle_q);
	end

endmodule
`default_nettype wire

[sv/pst_front.sv]
// Front stages: offsets to the centre, squared distance test, vector set-up.
`default_nettype none
module pst_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  signed [15:0]  touch_x,
	input  wire  signed [15:0]  touch_y,
	input  pst_pkg::geom_t      geom,
	output logic                out_valid,
	input  wire                 out_ready,
	output pst_pkg::vec_t       out_d
);
	import pst_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic r1, r2, r3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [39:0] dx2_s2, dy2_s2;
	vec_t vec_s2, vec_s3, vec_n;
	logic signed [VEC_W-1:0] xsc, ysc;

	assign r3 = !v_s3 | out_ready;
	assign r2 = !v_s2 | r3;
	assign r1 = !v_s1 | r2;
	assign in_ready = r1 & !geom.busy;

	assign xsc = VEC_W'(dx_s1) <<< 12;
	assign ysc = VEC_W'(dy_s1) <<< 12;

	// stage 3 item with the radius verdict filled in
	always_comb begin
		vec_n        = vec_s2;
		vec_n.in_rad = ({1'b0, dx2_s2} + {1'b0, dy2_s2}) <= {9'b0, geom.rsq};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid & !geom.busy;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			dx_s1 <= DIFF_W'(touch_x) - geom.cx;
			dy_s1 <= DIFF_W'(touch_y) - geom.cy;
		end
		if (r2) begin
			dx2_s2 <= 40'(dx_s1 * dx_s1);
			dy2_s2 <= 40'(dy_s1 * dy_s1);
			vec_s2.in_rad <= 1'b0;
			vec_s2.zero   <= (dx_s1 == 0) && (dy_s1 == 0);
			if (dx_s1 < 0) begin
				vec_s2.x <= -xsc;
				vec_s2.y <= -ysc;
				vec_s2.z <= HALF_TURN;
			end else begin
				vec_s2.x <= xsc;
				vec_s2.y <= ysc;
				vec_s2.z <= '0;
			end
		end
		if (r3)
			vec_s3 <= vec_n;
	end

	assign out_valid = v_s3;
	assign out_d     = vec_s3;

endmodule
`default_nettype wire

[sv/pst_cordic_stage.sv]
// One vectoring CORDIC iteration with its own pipeline register.
`default_nettype none
module pst_cordic_stage (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [pst_pkg::IDX_W-1:0]    step,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  pst_pkg::vec_t                in_d,
	output logic                         out_valid,
	input  wire                          out_ready,
	output pst_pkg::vec_t                out_d
);
	import pst_pkg::*;

	logic v_q;
	vec_t d_q;
	logic signed [VEC_W-1:0] xs, ys;
	logic [31:0] at;

	assign in_ready = !v_q | out_ready;
	assign xs = in_d.x >>> step;
	assign ys = in_d.y >>> step;
	assign at = {2'b0, atan_at(step)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (in_ready)
			v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			d_q.in_rad <= in_d.in_rad;
			d_q.zero   <= in_d.zero;
			if (in_d.y >= 0) begin
				d_q.x <= in_d.x + ys;
				d_q.y <= in_d.y - xs;
				d_q.z <= in_d.z + at;
			end else begin
				d_q.x <= in_d.x - ys;
				d_q.y <= in_d.y + xs;
				d_q.z <= in_d.z - at;
			end
		end
	end

	assign out_valid = v_q;
	assign out_d     = d_q;

endmodule
`default_nettype wire

[sv/pst_back.sv]
// Back stages: touch angle scaling and the wrap-aware slice bound compare.
`default_nettype none
module pst_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  pst_pkg::vec_t       in_d,
	input  pst_pkg::geom_t      geom,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                hit,
	output logic                within_radius
);
	import pst_pkg::*;

	localparam logic signed [BND_W-1:0] FULL_128THS = BND_W'(46080);

	logic v_s1, v_s2, r1, r2;
	logic [31:0] ta;
	logic [37:0] m_s1;
	logic        in_rad_s1;
	logic        hit_s2, in_rad_s2;
	logic signed [40:0] mm, bmin, bmax, blo, bhi;
	logic inang;

	assign r2 = !v_s2 | out_ready;
	assign r1 = !v_s1 | r2;
	assign in_ready = r1;

	// angle measured from up: atan2 minus a quarter turn, mod a full turn
	assign ta = (in_d.zero ? 32'h0 : in_d.z) - QUARTER_TURN;

	// ta*46080 against bound*2^32 reduces to ta*45 against bound*2^22
	assign mm   = signed'({3'b0, m_s1});
	assign bmin = 41'(geom.fmin) <<< 22;
	assign bmax = 41'(geom.fmax) <<< 22;
	assign blo  = 41'(FULL_128THS + geom.fmin) <<< 22;
	assign bhi  = 41'(geom.fmax - FULL_128THS) <<< 22;

	always_comb begin
		inang = (mm >= bmin) && (mm <= bmax);
		if ((geom.fmin < 0) && (mm > blo))
			inang = 1'b1;
		if ((geom.fmax > FULL_128THS) && (mm < bhi))
			inang = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			m_s1      <= 38'(ta) * 38'd45;
			in_rad_s1 <= in_d.in_rad;
		end
		if (r2) begin
			hit_s2    <= in_rad_s1 & inang;
			in_rad_s2 <= in_rad_s1;
		end
	end

	assign out_valid     = v_s2;
	assign hit           = hit_s2;
	assign within_radius = in_rad_s2;

endmodule
`default_nettype wire

[sv/pie_sector_hit_test_top.sv]
// Top level of the pie sector hit test pipeline.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[15:0]
//  in      | in        | in_valid / in_ready    | touch_x, touch_y (signed)
//  out     | out       | out_valid / out_ready  | hit, within_radius
//
// One request per cycle sustained while out_ready is high and no centre recompute
// runs; the pipe holds one register per vectoring CORDIC iteration.
// After any config write the centre sequencer runs a reciprocal multiply, a set-up
// step, the rotation CORDIC iterations and the final multiply/add steps in turn;
// in_ready stays low meanwhile. Reset restores the register defaults at once.
// Every stage has its own valid bit and holds under back-pressure, so bubbles
// are squeezed out and nothing is lost or repeated on a stall.
`default_nettype none
module pie_sector_hit_test_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [2:0]          cfg_index,
	input  wire  [15:0]         cfg_data,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  signed [15:0]  touch_x,
	input  wire  signed [15:0]  touch_y,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                hit,
	output logic                within_radius
);
	import pst_pkg::*;

	geom_t geom;

	// chain of vectoring items: index 0 leaves the front, CORDIC_STEPS enters the back
	vec_t vd    [CORDIC_STEPS+1];
	logic vv    [CORDIC_STEPS+1];
	logic vr    [CORDIC_STEPS+1];

	pst_centre u_centre (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	pst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.touch_x   (touch_x),
		.touch_y   (touch_y),
		.geom      (geom),
		.out_valid (vv[0]),
		.out_ready (vr[0]),
		.out_d     (vd[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		pst_cordic_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (IDX_W'(i)),
			.in_valid  (vv[i]),
			.in_ready  (vr[i]),
			.in_d      (vd[i]),
			.out_valid (vv[i+1]),
			.out_ready (vr[i+1]),
			.out_d     (vd[i+1])
		);
	end

	pst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (vv[CORDIC_STEPS]),
		.in_ready      (vr[CORDIC_STEPS]),
		.in_d          (vd[CORDIC_STEPS]),
		.geom          (geom),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.within_radius (within_radius)
	);

endmodule
`default_nettype wire

[sv/pst_checker.sv]
// Port-level checker for the pie sector hit test, bound to the top level.
`default_nettype none
module pst_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        cfg_valid,
	input wire        cfg_ready,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        hit,
	input wire        within_radius
);

	// a hit is only possible inside the radius
	a_hit_within: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!hit || within_radius))
		else $error("hit reported outside radius");

	// a config write starts the centre recompute, which blocks new requests
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> !in_ready)
		else $error("request accepted during centre recompute");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(hit) && $stable(within_radius)))
		else $error("result changed under stall");

endmodule

bind pie_sector_hit_test_top pst_checker u_pst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.within_radius (within_radius)
);
`default_nettype wire
